[hw/rtl/ucs_pkg.sv]
// types, constants and helper functions shared by the url component splitter
package ucs_pkg;

    // url section that the parser is in
    typedef enum logic [2:0] {
        PH_PROTOCOL,
        PH_HOST,
        PH_PORT,
        PH_PATH,
        PH_QUERY
    } phase_t;

    // part of the "://" marker held back in the protocol section
    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_COLON,
        HELD_COLON_SLASH
    } held_t;

    // port text conversion stage
    typedef enum logic [1:0] {
        NS_SPACE,
        NS_SIGN,
        NS_DIGITS,
        NS_DONE
    } num_stage_t;

    // part tags
    localparam logic [2:0] PART_PROTOCOL = 3'd0;
    localparam logic [2:0] PART_HOST     = 3'd1;
    localparam logic [2:0] PART_PORT     = 3'd2;
    localparam logic [2:0] PART_PATH     = 3'd3;
    localparam logic [2:0] PART_QUERY    = 3'd4;
    localparam logic [2:0] PART_SEP      = 3'd5;

    // end status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOT_URL  = 2'd1;
    localparam logic [1:0] STATUS_BAD_PORT = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // port magnitude width and product width for the times-ten update
    localparam int MAG_W  = 64;
    localparam int PROD_W = MAG_W + 4;

    // one tagged output byte with its end-of-url information
    typedef struct packed {
        logic [2:0]  part;
        logic [7:0]  ch;
        logic        url_end;
        logic [1:0]  status;
        logic [15:0] port_number;
        logic        port_found;
    } result_t;

    // all results caused by one request
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } step_out_t;

    // ascii A-Z to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // space, tab, lf, vt, ff, cr
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

[hw/rtl/ucs_parse.sv]
// parser state and per-byte tagging logic of the url component splitter
module ucs_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          char_in,
    input  logic                last_char,
    output ucs_pkg::step_out_t  step_out
);

    ucs_pkg::phase_t               phase_reg, phase_next;
    ucs_pkg::held_t                held_reg, held_next;
    ucs_pkg::num_stage_t           ns_reg, ns_next;
    logic                          neg_reg, neg_next;
    logic                          seen_reg, seen_next;
    logic                          rex_reg, rex_next;
    logic [ucs_pkg::MAG_W-1:0]     mag_reg, mag_next;

    logic [ucs_pkg::PROD_W-1:0]    prod;
    logic [ucs_pkg::PROD_W-1:0]    limit;

    // magnitude times ten plus the digit, and the long limit for the sign
    assign prod = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                + {{(ucs_pkg::PROD_W-4){1'b0}}, char_in[3:0]};
    assign limit = neg_reg ? {4'b0, 1'b1, {(ucs_pkg::MAG_W-1){1'b0}}}
                           : {5'b0, {(ucs_pkg::MAG_W-1){1'b1}}};

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ucs_pkg::PH_PROTOCOL;
            held_reg  <= ucs_pkg::HELD_NONE;
            ns_reg    <= ucs_pkg::NS_SPACE;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            rex_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            ns_reg    <= ns_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            rex_reg   <= rex_next;
            mag_reg   <= mag_next;
        end
    end

    // next state and tagged results for one byte
    always_comb
    begin
        logic [1:0] n;
        logic       do_proto;
        logic [1:0] st;
        logic [1:0] last_idx;
        logic [15:0] port;

        phase_next = phase_reg;
        held_next  = held_reg;
        ns_next    = ns_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        rex_next   = rex_reg;
        mag_next   = mag_reg;
        step_out   = '0;
        n          = 2'd0;
        do_proto   = 1'b0;
        st         = ucs_pkg::STATUS_OK;
        last_idx   = 2'd0;
        port       = 16'd0;

        unique case (phase_reg)
            ucs_pkg::PH_PROTOCOL:
            begin
                unique case (held_reg)
                    ucs_pkg::HELD_NONE:
                    begin
                        do_proto = 1'b1;
                    end
                    ucs_pkg::HELD_COLON:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                        begin
                            held_next = ucs_pkg::HELD_COLON_SLASH;
                        end
                        else
                        begin
                            held_next = ucs_pkg::HELD_NONE;
                            step_out.res[n].part = ucs_pkg::PART_PROTOCOL;
                            step_out.res[n].ch   = ucs_pkg::CH_COLON;
                            n = n + 2'd1;
                            do_proto = 1'b1;
                        end
                    end
                    default:
                    begin
                        held_next = ucs_pkg::HELD_NONE;
                        if (char_in == ucs_pkg::CH_SLASH)
                        begin
                            // marker confirmed
                            step_out.res[0].part = ucs_pkg::PART_SEP;
                            step_out.res[0].ch   = ucs_pkg::CH_COLON;
                            step_out.res[1].part = ucs_pkg::PART_SEP;
                            step_out.res[1].ch   = ucs_pkg::CH_SLASH;
                            step_out.res[2].part = ucs_pkg::PART_SEP;
                            step_out.res[2].ch   = ucs_pkg::CH_SLASH;
                            n = 2'd3;
                            phase_next = ucs_pkg::PH_HOST;
                        end
                        else
                        begin
                            // marker broken, release held bytes
                            step_out.res[0].part = ucs_pkg::PART_PROTOCOL;
                            step_out.res[0].ch   = ucs_pkg::CH_COLON;
                            step_out.res[1].part = ucs_pkg::PART_PROTOCOL;
                            step_out.res[1].ch   = ucs_pkg::CH_SLASH;
                            n = 2'd2;
                            do_proto = 1'b1;
                        end
                    end
                endcase
            end
            ucs_pkg::PH_HOST:
            begin
                if (char_in == ucs_pkg::CH_SLASH)
                begin
                    step_out.res[0].part = ucs_pkg::PART_PATH;
                    step_out.res[0].ch   = char_in;
                    phase_next = ucs_pkg::PH_PATH;
                end
                else if (char_in == ucs_pkg::CH_COLON)
                begin
                    step_out.res[0].part = ucs_pkg::PART_SEP;
                    step_out.res[0].ch   = char_in;
                    phase_next = ucs_pkg::PH_PORT;
                end
                else
                begin
                    step_out.res[0].part = ucs_pkg::PART_HOST;
                    step_out.res[0].ch   = ucs_pkg::to_lower(char_in);
                end
                n = 2'd1;
            end
            ucs_pkg::PH_PORT:
            begin
                if (char_in == ucs_pkg::CH_SLASH)
                begin
                    step_out.res[0].part = ucs_pkg::PART_PATH;
                    phase_next = ucs_pkg::PH_PATH;
                end
                else
                begin
                    step_out.res[0].part = ucs_pkg::PART_PORT;
                    // decimal conversion of the port text
                    if (ns_reg == ucs_pkg::NS_SPACE && ucs_pkg::is_space(char_in))
                    begin
                        ns_next = ns_reg;
                    end
                    else if (ns_reg == ucs_pkg::NS_SPACE &&
                             (char_in == ucs_pkg::CH_PLUS || char_in == ucs_pkg::CH_MINUS))
                    begin
                        neg_next = (char_in == ucs_pkg::CH_MINUS);
                        ns_next  = ucs_pkg::NS_SIGN;
                    end
                    else if (ns_reg == ucs_pkg::NS_DONE)
                    begin
                        ns_next = ns_reg;
                    end
                    else if (!ucs_pkg::is_digit(char_in))
                    begin
                        ns_next = ucs_pkg::NS_DONE;
                    end
                    else
                    begin
                        ns_next   = ucs_pkg::NS_DIGITS;
                        seen_next = 1'b1;
                        if (!rex_reg)
                        begin
                            if (prod > limit)
                            begin
                                rex_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = prod[ucs_pkg::MAG_W-1:0];
                            end
                        end
                    end
                end
                step_out.res[0].ch = char_in;
                n = 2'd1;
            end
            ucs_pkg::PH_PATH:
            begin
                if (char_in == ucs_pkg::CH_QMARK)
                begin
                    step_out.res[0].part = ucs_pkg::PART_SEP;
                    phase_next = ucs_pkg::PH_QUERY;
                end
                else
                begin
                    step_out.res[0].part = ucs_pkg::PART_PATH;
                end
                step_out.res[0].ch = char_in;
                n = 2'd1;
            end
            default:
            begin
                step_out.res[0].part = ucs_pkg::PART_QUERY;
                step_out.res[0].ch   = char_in;
                n = 2'd1;
            end
        endcase

        // ordinary protocol byte, a colon may start the marker
        if (do_proto)
        begin
            if (char_in == ucs_pkg::CH_COLON)
            begin
                held_next = ucs_pkg::HELD_COLON;
            end
            else
            begin
                step_out.res[n].part = ucs_pkg::PART_PROTOCOL;
                step_out.res[n].ch   = ucs_pkg::to_lower(char_in);
                n = n + 2'd1;
            end
        end

        // end of url: release held bytes, report status, clear state
        if (last_char)
        begin
            if (held_next != ucs_pkg::HELD_NONE)
            begin
                step_out.res[n].part = ucs_pkg::PART_PROTOCOL;
                step_out.res[n].ch   = ucs_pkg::CH_COLON;
                n = n + 2'd1;
            end
            if (held_next == ucs_pkg::HELD_COLON_SLASH)
            begin
                step_out.res[n].part = ucs_pkg::PART_PROTOCOL;
                step_out.res[n].ch   = ucs_pkg::CH_SLASH;
                n = n + 2'd1;
            end

            if (phase_next == ucs_pkg::PH_PROTOCOL)
            begin
                st = ucs_pkg::STATUS_NOT_URL;
            end
            else if (rex_next || (!neg_next && mag_next[ucs_pkg::MAG_W-1:16] != '0))
            begin
                st = ucs_pkg::STATUS_BAD_PORT;
            end
            else
            begin
                st = ucs_pkg::STATUS_OK;
            end

            if (st == ucs_pkg::STATUS_OK && seen_next)
            begin
                port = neg_next ? (16'd0 - mag_next[15:0]) : mag_next[15:0];
            end

            last_idx = n - 2'd1;
            step_out.res[last_idx].url_end     = 1'b1;
            step_out.res[last_idx].status      = st;
            step_out.res[last_idx].port_number = port;
            step_out.res[last_idx].port_found  = seen_next;

            phase_next = ucs_pkg::PH_PROTOCOL;
            held_next  = ucs_pkg::HELD_NONE;
            ns_next    = ucs_pkg::NS_SPACE;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            rex_next   = 1'b0;
            mag_next   = '0;
        end

        step_out.count = n;
    end

endmodule

[hw/rtl/ucs_rbuf.sv]
// three-entry result register that drains one tagged byte per cycle while out_ready is high
module ucs_rbuf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ucs_pkg::step_out_t  step_out,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output ucs_pkg::result_t    head
);

    logic [1:0]                 count_reg, count_next;
    ucs_pkg::result_t [2:0]     entry_reg, entry_next;
    logic                       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign head      = entry_reg[0];

    // load a new set of results or shift one out
    always_comb
    begin
        count_next = count_reg;
        entry_next = entry_reg;
        if (load)
        begin
            entry_next = step_out.res;
            count_next = step_out.count;
        end
        else if (pop)
        begin
            entry_next[0] = entry_reg[1];
            entry_next[1] = entry_reg[2];
            count_next    = count_reg - 2'd1;
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[hw/rtl/url_component_splitter.sv]
// top level of the url component splitter
//
// Input channel: one url byte per request on char_in, with last_char set on
// the final byte of a url. Output channel: tagged bytes (part, char_out);
// the final result of a url carries url_end, status, port_number and
// port_found. Both channels use valid/ready.
// An accepted byte waits in the input register, where the parser tags it;
// its results are then loaded into the result register, from which the
// first result shows on out_valid.
// Throughput is one byte per cycle while each byte yields one result and
// out_ready stays high. A byte that yields two or three results (the '://'
// marker or released marker bytes) holds the input register until the result
// register has drained to its last entry; a held ':' or ":/" yields no result for that byte.
// Reset clears the parser to the protocol section and empties both
// registers. When the receiver stalls, the result register keeps its data,
// the parser waits, and in_ready drops once the input register is full.
module url_component_splitter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  part,
    output logic [7:0]  char_out,
    output logic        url_end,
    output logic [1:0]  status,
    output logic [15:0] port_number,
    output logic        port_found
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         char_reg;
    logic               last_reg;
    logic               can_load;
    logic               consume;
    ucs_pkg::step_out_t step_out;
    ucs_pkg::result_t   head;

    // input register handshake
    assign consume       = in_valid_reg && can_load;
    assign in_ready      = !in_valid_reg || consume;
    assign in_valid_next = (in_valid && in_ready) ? 1'b1 :
                           (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
            last_reg <= last_char;
        end
    end

    // byte parser
    ucs_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (consume),
        .char_in   (char_reg),
        .last_char (last_reg),
        .step_out  (step_out)
    );

    // result register
    ucs_rbuf u_rbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume),
        .step_out  (step_out),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign part        = head.part;
    assign char_out    = head.ch;
    assign url_end     = head.url_end;
    assign status      = head.status;
    assign port_number = head.port_number;
    assign port_found  = head.port_found;

`ifndef SYNTHESIS
    // end information only on the final result of a url
    a_end_fields_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !url_end |-> status == ucs_pkg::STATUS_OK && !port_found
                                  && port_number == 16'd0)
        else $error("end fields set on a result without url_end");

    // a port number is reported only for a good url with a converted port
    a_port_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && url_end && port_number != 16'd0
            |-> status == ucs_pkg::STATUS_OK && port_found)
        else $error("port number reported without a valid port");

    // a waiting request is taken in as soon as the result register is empty
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid |-> consume)
        else $error("parser stalled with an empty result register");
`endif

endmodule
